// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the grouping DP block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bgs_pkg.sv =====
// Package: widths, constants, control structs and helpers of the grouping DP block.
`default_nettype none

package bgs_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int SET_W     = MAX_ITEMS;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int N_W       = 5;
  localparam int WEIGHT_W  = 32;
  localparam int SCORE_W   = 40;

  // APB register map
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic REG_ITEM_COUNT = 1'b0;
  localparam logic [N_W-1:0] ITEM_COUNT_RESET = N_W'(16);

  // Starting best value for every non-empty set
  localparam logic [SCORE_W-1:0] START_VALUE = SCORE_W'(0) - SCORE_W'(2000000000);

  // Control from the top level to the engine
  typedef struct packed {
    logic                start;
    logic                ack;
    logic [SET_W-1:0]    full;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [WEIGHT_W-1:0] wdata;
  } bgs_ctl_t;

  // Status from the engine to the top level
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SCORE_W-1:0] total;
  } bgs_status_t;

  // Index of the lowest set bit (zero for an empty vector)
  function automatic logic [IDX_W-1:0] lowest_bit(input logic [SET_W-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = SET_W - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bgs_cfg_regs.sv =====
// APB register file holding the item count.
`default_nettype none

module bgs_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bgs_pkg::PADDR_W-1:0]  paddr,
  input  logic [bgs_pkg::PDATA_W-1:0]  pwdata,
  output logic [bgs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [bgs_pkg::N_W-1:0]      item_count
);
  import bgs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ITEM_COUNT);

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= ITEM_COUNT_RESET;
    end else if (wr_en) begin
      item_count <= pwdata[N_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    if (paddr[2] == REG_ITEM_COUNT) begin
      prdata = PDATA_W'(item_count);
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bgs_engine.sv =====
// Sequencer, memories and shared adder for the group score and partition DP passes.
`default_nettype none

module bgs_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  bgs_pkg::bgs_ctl_t    ctl,
  output bgs_pkg::bgs_status_t status
);
  import bgs_pkg::*;

  localparam int MAT_DEPTH = 1 << ADDR_W;
  localparam int SET_DEPTH = 1 << SET_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZERO,
    ST_SC_SET,
    ST_SC_RUN,
    ST_SC_WRITE,
    ST_DP_SET,
    ST_DP_BASE,
    ST_DP_SUB,
    ST_DONE
  } state_t;

  state_t state;

  // Sequencer registers
  logic [SET_W-1:0]   full;
  logic [SET_W-1:0]   set_cur;
  logic [SET_W-1:0]   pend;
  logic [SET_W-1:0]   cur_sub;
  logic [IDX_W-1:0]   kk;
  logic               dir;
  logic               rd_pending;
  logic               acc_init;
  logic [SCORE_W-1:0] acc;
  logic [SCORE_W-1:0] base;
  logic [SCORE_W-1:0] total;

  // Memories
  logic [WEIGHT_W-1:0] w_mem    [MAT_DEPTH];
  logic [SCORE_W-1:0]  gs_mem   [SET_DEPTH];
  logic [SCORE_W-1:0]  best_mem [SET_DEPTH];

  logic [ADDR_W-1:0]   w_raddr;
  logic [WEIGHT_W-1:0] w_rdata;
  logic [SET_W-1:0]    gs_raddr;
  logic [SET_W-1:0]    gs_waddr;
  logic [SCORE_W-1:0]  gs_wdata;
  logic                gs_we;
  logic [SCORE_W-1:0]  gs_rdata;
  logic [SET_W-1:0]    best_raddr;
  logic [SET_W-1:0]    best_waddr;
  logic [SCORE_W-1:0]  best_wdata;
  logic                best_we;
  logic [SCORE_W-1:0]  best_rdata;

  // Derived set values
  logic [SET_W-1:0]  s_prime;
  logic [SET_W-1:0]  rest;
  logic [SET_W-1:0]  sub_next;
  logic [IDX_W-1:0]  k_low;
  logic [IDX_W-1:0]  j_low;

  // Shared adder
  logic [SCORE_W-1:0] add_a;
  logic [SCORE_W-1:0] add_b;
  logic               add_cin;
  logic [SCORE_W:0]   add_sum;
  logic               better;

  assign s_prime  = set_cur & (set_cur - SET_W'(1));
  assign rest     = full ^ set_cur;
  assign sub_next = (cur_sub - SET_W'(1)) & rest;
  assign k_low    = lowest_bit(set_cur);
  assign j_low    = lowest_bit(pend);

  // Score pass: acc + weight (first step: stored subset sum + diagonal).
  // DP pass: best[s] + half of the stored pair sum, rounded toward zero.
  always_comb begin
    if (state == ST_DP_SUB) begin
      add_a   = base;
      add_b   = {gs_rdata[SCORE_W-1], gs_rdata[SCORE_W-1:1]};
      add_cin = gs_rdata[SCORE_W-1] & gs_rdata[0];
    end else begin
      add_a   = acc_init ? gs_rdata : acc;
      add_b   = {{(SCORE_W - WEIGHT_W){w_rdata[WEIGHT_W-1]}}, w_rdata};
      add_cin = 1'b0;
    end
  end

  assign add_sum = {add_a[SCORE_W-1], add_a} + {add_b[SCORE_W-1], add_b}
                 + {{SCORE_W{1'b0}}, add_cin};
  assign better  = $signed(add_sum) > $signed({best_rdata[SCORE_W-1], best_rdata});

  // Memory addresses and write ports
  always_comb begin
    w_raddr    = '0;
    gs_raddr   = '0;
    gs_waddr   = set_cur;
    gs_wdata   = acc;
    gs_we      = 1'b0;
    best_raddr = set_cur;
    best_waddr = set_cur;
    best_wdata = START_VALUE;
    best_we    = 1'b0;
    unique case (state)
      ST_ZERO: begin
        gs_waddr   = '0;
        gs_wdata   = '0;
        gs_we      = 1'b1;
        best_waddr = '0;
        best_wdata = '0;
        best_we    = 1'b1;
      end
      ST_SC_SET: begin
        w_raddr  = {k_low, k_low};
        gs_raddr = s_prime;
      end
      ST_SC_RUN: begin
        w_raddr = dir ? {j_low, kk} : {kk, j_low};
      end
      ST_SC_WRITE: begin
        gs_we   = 1'b1;
        best_we = 1'b1;
      end
      ST_DP_SET: begin
        best_raddr = set_cur;
      end
      ST_DP_BASE: begin
        gs_raddr   = rest;
        best_raddr = full;
      end
      ST_DP_SUB: begin
        gs_raddr   = sub_next;
        best_raddr = set_cur | sub_next;
        best_waddr = set_cur | cur_sub;
        best_wdata = add_sum[SCORE_W-1:0];
        best_we    = better;
      end
      default: begin
      end
    endcase
  end

  // Weight matrix
  always_ff @(posedge clk) begin
    if (ctl.we) w_mem[ctl.waddr] <= ctl.wdata;
    w_rdata <= w_mem[w_raddr];
  end

  // Group pair sums (stored before halving)
  always_ff @(posedge clk) begin
    if (gs_we) gs_mem[gs_waddr] <= gs_wdata;
    gs_rdata <= gs_mem[gs_raddr];
  end

  // Best total per set
  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_waddr] <= best_wdata;
    best_rdata <= best_mem[best_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pending <= 1'b0;
      acc_init   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            full  <= ctl.full;
            state <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (full == '0) begin
            set_cur <= '0;
            state   <= ST_DP_SET;
          end else begin
            set_cur <= SET_W'(1);
            state   <= ST_SC_SET;
          end
        end
        ST_SC_SET: begin
          kk         <= k_low;
          pend       <= s_prime;
          dir        <= 1'b0;
          rd_pending <= 1'b1;
          acc_init   <= 1'b1;
          state      <= ST_SC_RUN;
        end
        ST_SC_RUN: begin
          // accumulate the word read last cycle, issue the next pair read
          if (acc_init || rd_pending) acc <= add_sum[SCORE_W-1:0];
          acc_init <= 1'b0;
          if (pend != '0) begin
            rd_pending <= 1'b1;
            dir        <= ~dir;
            if (dir) pend <= pend & (pend - SET_W'(1));
          end else begin
            rd_pending <= 1'b0;
            state      <= ST_SC_WRITE;
          end
        end
        ST_SC_WRITE: begin
          if (set_cur == full) begin
            set_cur <= '0;
            state   <= ST_DP_SET;
          end else begin
            set_cur <= set_cur + SET_W'(1);
            state   <= ST_SC_SET;
          end
        end
        ST_DP_SET: begin
          state <= ST_DP_BASE;
        end
        ST_DP_BASE: begin
          if (set_cur == full) begin
            total <= best_rdata;
            state <= ST_DONE;
          end else begin
            base    <= best_rdata;
            cur_sub <= rest;
            state   <= ST_DP_SUB;
          end
        end
        ST_DP_SUB: begin
          // walk submasks of the complement, one per cycle
          if (sub_next != '0) begin
            cur_sub <= sub_next;
          end else begin
            set_cur <= set_cur + SET_W'(1);
            state   <= ST_DP_SET;
          end
        end
        ST_DONE: begin
          if (ctl.ack) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign status.busy  = (state != ST_IDLE);
  assign status.done  = (state == ST_DONE);
  assign status.total = total;

endmodule

`default_nettype wire

// ===== hw/rtl/best_grouping_subset_dp_unit.sv =====
// Top level of the best grouping subset DP block.
//
// Usage:
//   Input channel (in_valid/in_stall; row, col, weight, last) loads the pair
//   weight matrix one transaction per cycle while the engine is idle. Entries
//   with row or col at or above item_count are dropped. A transaction with
//   last set starts the computation; in_stall stays high until its result
//   moves into the output register. Computation: a group score pass over
//   every set S (one weight read a cycle) and a submask DP pass (one submask
//   a cycle through the shared adder and the best-value memory port).
//   Output channel (out_valid/out_stall; best_total) carries one transaction
//   per last item from an output register; a stalled result holds, and new
//   load entries are still taken while it waits. A finished computation waits
//   for the output register to free up.
//   item_count sits at APB address 0 (reset 16, values above 16 act as 16);
//   write it only while the block is idle.
//   Reset (rst, synchronous) idles the engine and clears out_valid. The weight
//   and working memories are not cleared; every working-memory entry is written before use.
`default_nettype none
`include "assert_macros.svh"

module best_grouping_subset_dp_unit (
  input  logic                          clk,
  input  logic                          rst,
  // load channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bgs_pkg::IDX_W-1:0]     row,
  input  logic [bgs_pkg::IDX_W-1:0]     col,
  input  logic signed [bgs_pkg::WEIGHT_W-1:0] weight,
  input  logic                          last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [bgs_pkg::SCORE_W-1:0]  best_total,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgs_pkg::PADDR_W-1:0]   paddr,
  input  logic [bgs_pkg::PDATA_W-1:0]   pwdata,
  output logic [bgs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bgs_pkg::*;

  logic [N_W-1:0]   item_count;
  logic [N_W-1:0]   n_items;
  logic [SET_W:0]   full_ext;
  logic             in_take;
  logic             in_range;
  logic             out_load;
  bgs_ctl_t         ctl;
  bgs_status_t      st;

  bgs_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .item_count (item_count)
  );

  // Clamp the item count and build the full-set mask
  assign n_items  = (item_count > N_W'(MAX_ITEMS)) ? N_W'(MAX_ITEMS) : item_count;
  assign full_ext = ((SET_W + 1)'(1) << n_items) - (SET_W + 1)'(1);

  // Load handshake
  assign in_stall = st.busy;
  assign in_take  = in_valid && !in_stall;
  assign in_range = ({1'b0, row} < n_items) && ({1'b0, col} < n_items);

  // Result hand-off into the output register
  assign out_load = st.done && (!out_valid || !out_stall);

  assign ctl.start = in_take && last;
  assign ctl.ack   = out_load;
  assign ctl.full  = full_ext[SET_W-1:0];
  assign ctl.we    = in_take && in_range;
  assign ctl.waddr = {row, col};
  assign ctl.wdata = weight;

  bgs_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .status (st)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) best_total <= st.total;
  end

  // Checks
  `ASSERT_CLK(a_out_from_engine, clk, rst, $rose(out_valid) |-> $past(st.done), "no done")
  `ASSERT_CLK(a_last_starts, clk, rst, (in_take && last) |=> st.busy, "engine not started")
  `ASSERT_CLK(a_done_busy, clk, rst, st.done |-> (st.busy && in_stall), "done while idle")
  `ASSERT_CLK_NR(a_reset_out, clk, rst |=> !out_valid, "out_valid set after reset")

endmodule

`default_nettype wire
